### rtl/core/sfe_pkg.sv
`timescale 1ns / 1ps

package sfe_pkg;

  // Frame control characters and register reset
  localparam logic [7:0] CH_SOH        = 8'h01;
  localparam logic [7:0] CH_STX        = 8'h02;
  localparam logic [7:0] CH_ETX        = 8'h03;
  localparam logic [7:0] STATION_RESET = 8'h30;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_SEVEN   = 8'h37;

  // Microprogram geometry
  localparam int unsigned STEP_W = 4;

  // Byte source for one step
  typedef enum logic [3:0] {
    SRC_SOH,
    SRC_STATION,
    SRC_CMD_HI,
    SRC_CMD_LO,
    SRC_STX,
    SRC_DNO_HI,
    SRC_DNO_LO,
    SRC_DATA,
    SRC_ETX,
    SRC_SUM_HI,
    SRC_SUM_LO
  } src_t;

  // Sequencing after a step
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_SKIP_DATA,
    JMP_LOOP_DATA,
    JMP_END
  } jump_t;

  typedef struct packed {
    src_t              src;
    logic              add_sum;
    logic              last;
    jump_t             jump;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic digits_zero;
    logic digits_last;
  } status_t;

  // Step addresses
  localparam logic [STEP_W-1:0] STEP_SOH     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_STATION = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CMD_HI  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CMD_LO  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_STX     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DNO_HI  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DNO_LO  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DATA    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_ETX     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_SUM_HI  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SUM_LO  = 4'd10;

  // Frame microprogram
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{src: SRC_SUM_LO, add_sum: 1'b0, last: 1'b1, jump: JMP_END, target: STEP_SOH};
    case (step)
      STEP_SOH:     w = '{SRC_SOH,     1'b0, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_STATION: w = '{SRC_STATION, 1'b1, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_CMD_HI:  w = '{SRC_CMD_HI,  1'b1, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_CMD_LO:  w = '{SRC_CMD_LO,  1'b1, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_STX:     w = '{SRC_STX,     1'b1, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_DNO_HI:  w = '{SRC_DNO_HI,  1'b1, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_DNO_LO:  w = '{SRC_DNO_LO,  1'b1, 1'b0, JMP_SKIP_DATA, STEP_ETX};
      STEP_DATA:    w = '{SRC_DATA,    1'b1, 1'b0, JMP_LOOP_DATA, STEP_DATA};
      STEP_ETX:     w = '{SRC_ETX,     1'b1, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_SUM_HI:  w = '{SRC_SUM_HI,  1'b0, 1'b0, JMP_NEXT,      STEP_SOH};
      STEP_SUM_LO:  w = '{SRC_SUM_LO,  1'b0, 1'b1, JMP_END,       STEP_SOH};
      default:      w = '{SRC_SUM_LO,  1'b0, 1'b1, JMP_END,       STEP_SOH};
    endcase
    return w;
  endfunction

  // Uppercase ASCII hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = ASCII_ZERO + {4'd0, n};
    end else begin
      c = ASCII_SEVEN + {4'd0, n};
    end
    return c;
  endfunction

endpackage

### rtl/core/sfe_useq.sv
`timescale 1ns / 1ps

module sfe_useq (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  sfe_pkg::status_t status,
  output sfe_pkg::ctrl_t   ctrl,
  output logic             busy
);

  logic [sfe_pkg::STEP_W-1:0] step;
  logic [sfe_pkg::STEP_W-1:0] step_next;
  logic                       busy_next;

  // Fetch the control word for the current step
  assign ctrl = sfe_pkg::ucode_rom(step);

  // Pick the next step from the jump field
  always_comb begin
    step_next = step;
    busy_next = busy;
    if (go) begin
      step_next = sfe_pkg::STEP_SOH;
      busy_next = 1'b1;
    end else if (busy) begin
      case (ctrl.jump)
        sfe_pkg::JMP_NEXT: begin
          step_next = step + 1'b1;
        end
        sfe_pkg::JMP_SKIP_DATA: begin
          step_next = status.digits_zero ? ctrl.target : step + 1'b1;
        end
        sfe_pkg::JMP_LOOP_DATA: begin
          step_next = status.digits_last ? step + 1'b1 : ctrl.target;
        end
        sfe_pkg::JMP_END: begin
          step_next = sfe_pkg::STEP_SOH;
          busy_next = 1'b0;
        end
        default: begin
          step_next = sfe_pkg::STEP_SOH;
          busy_next = 1'b0;
        end
      endcase
    end
  end

  // Hold step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= sfe_pkg::STEP_SOH;
      busy <= 1'b0;
    end else begin
      step <= step_next;
      busy <= busy_next;
    end
  end

endmodule

### rtl/core/servo_serial_frame_encoder_top.sv
`timescale 1ns / 1ps

// Channel   Handshake                     Payload
// -------   ---------                     -------
// request   start, busy (accept: start&!busy) command_code, data_number, has_data,
//                                          data_digits, data_value
// frame     frame_strobe (one per byte)   frame_byte, last_byte
// config    station_write                 station
//
// A frame holds 10 + D bytes, D being the data digit count after clamping
// (0 without data): the microcode sequencer emits one frame byte per step.
// Bytes leave through an output register in the cycle after their step, so busy
// drops while the final checksum byte is still on the ports.
// Synchronous reset clears the sequencer and sets the station to '0'.
// The receiver cannot stall; every strobed byte is taken.

module servo_serial_frame_encoder_top #(
  parameter int unsigned MAX_DATA_DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               station_write,
  input  logic [7:0]         station,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         command_code,
  input  logic [7:0]         data_number,
  input  logic               has_data,
  input  logic [3:0]         data_digits,
  input  logic signed [31:0] data_value,
  output logic               frame_strobe,
  output logic [7:0]         frame_byte,
  output logic               last_byte
);

  localparam int unsigned DW    = 4 * MAX_DATA_DIGITS;
  localparam int unsigned CW    = $clog2(MAX_DATA_DIGITS + 1);
  localparam int unsigned IDX_W = (MAX_DATA_DIGITS > 1) ? $clog2(MAX_DATA_DIGITS) : 1;
  localparam logic [4:0]  MAX_D = 5'(MAX_DATA_DIGITS);

  logic [7:0]       station_reg;
  logic [7:0]       cmd;
  logic [7:0]       dno;
  logic [DW-1:0]    data;
  logic [CW-1:0]    dcount;
  logic [7:0]       sum;
  logic             go;
  logic [4:0]       digits_clamped;
  logic [IDX_W-1:0] nib_idx;
  logic [3:0]       data_nib;
  logic [7:0]       byte_sel;
  sfe_pkg::ctrl_t   ctrl;
  sfe_pkg::status_t status;

  assign go = start & ~busy;

  // Clamp the digit count; no data field sends none
  always_comb begin
    digits_clamped = 5'd0;
    if (has_data) begin
      digits_clamped = ({1'b0, data_digits} > MAX_D) ? MAX_D : {1'b0, data_digits};
    end
  end

  assign status.digits_zero = (dcount == '0);
  assign status.digits_last = (dcount == CW'(1));

  sfe_useq u_useq (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Select the pending data digit
  assign nib_idx  = IDX_W'(dcount - 1'b1);
  assign data_nib = data[4 * nib_idx +: 4];

  // Route the byte named by the control word
  always_comb begin
    case (ctrl.src)
      sfe_pkg::SRC_SOH:     byte_sel = sfe_pkg::CH_SOH;
      sfe_pkg::SRC_STATION: byte_sel = station_reg;
      sfe_pkg::SRC_CMD_HI:  byte_sel = sfe_pkg::hex_char(cmd[7:4]);
      sfe_pkg::SRC_CMD_LO:  byte_sel = sfe_pkg::hex_char(cmd[3:0]);
      sfe_pkg::SRC_STX:     byte_sel = sfe_pkg::CH_STX;
      sfe_pkg::SRC_DNO_HI:  byte_sel = sfe_pkg::hex_char(dno[7:4]);
      sfe_pkg::SRC_DNO_LO:  byte_sel = sfe_pkg::hex_char(dno[3:0]);
      sfe_pkg::SRC_DATA:    byte_sel = sfe_pkg::hex_char(data_nib);
      sfe_pkg::SRC_ETX:     byte_sel = sfe_pkg::CH_ETX;
      sfe_pkg::SRC_SUM_HI:  byte_sel = sfe_pkg::hex_char(sum[7:4]);
      sfe_pkg::SRC_SUM_LO:  byte_sel = sfe_pkg::hex_char(sum[3:0]);
      default:              byte_sel = sfe_pkg::CH_ETX;
    endcase
  end

  // Hold the station register
  always_ff @(posedge clk) begin
    if (rst) begin
      station_reg <= sfe_pkg::STATION_RESET;
    end else if (station_write) begin
      station_reg <= station;
    end
  end

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (go) begin
      cmd  <= command_code;
      dno  <= data_number;
      data <= DW'(data_value);
    end
  end

  // Load and drop the digit count, accumulate the checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      dcount <= '0;
      sum    <= 8'd0;
    end else if (go) begin
      dcount <= CW'(digits_clamped);
      sum    <= 8'd0;
    end else if (busy) begin
      if (ctrl.src == sfe_pkg::SRC_DATA) begin
        dcount <= dcount - 1'b1;
      end
      if (ctrl.add_sum) begin
        sum <= sum + byte_sel;
      end
    end
  end

  // Register the outgoing byte
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_strobe <= 1'b0;
    end else begin
      frame_strobe <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      frame_byte <= byte_sel;
      last_byte  <= ctrl.last;
    end
  end

endmodule

### sim/servo_serial_frame_encoder_checker.sv
`timescale 1ns / 1ps

module servo_serial_frame_encoder_checker #(
  parameter int unsigned MAX_DATA_DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               station_write,
  input  logic [7:0]         station,
  input  logic               start,
  input  logic               busy,
  input  logic [7:0]         command_code,
  input  logic [7:0]         data_number,
  input  logic               has_data,
  input  logic [3:0]         data_digits,
  input  logic signed [31:0] data_value,
  input  logic               frame_strobe,
  input  logic [7:0]         frame_byte,
  input  logic               last_byte,
  output int                 errors,
  output int                 pending,
  output int                 frames_done,
  output int                 bytes_done
);

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } frame_char_t;

  frame_char_t chars_due[$];
  logic [7:0]  station_now;

  // Uppercase ASCII hex digit of one nibble
  function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
    string digits_set;
    digits_set = "0123456789ABCDEF";
    return digits_set[nib];
  endfunction

  // Expand one request into the frame bytes it must produce
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] dno,
                             input logic has, input logic [3:0] dig,
                             input logic [31:0] val);
    logic [63:0] wide;
    logic [7:0]  body[$];
    logic [7:0]  sum;
    int          ndig;
    wide = {{32{val[31]}}, val};
    ndig = 0;
    if (has) begin
      ndig = (dig > MAX_DATA_DIGITS) ? MAX_DATA_DIGITS : dig;
    end
    body.push_back(station_now);
    body.push_back(ascii_nibble(cmd[7:4]));
    body.push_back(ascii_nibble(cmd[3:0]));
    body.push_back(sfe_pkg::CH_STX);
    body.push_back(ascii_nibble(dno[7:4]));
    body.push_back(ascii_nibble(dno[3:0]));
    for (int d = ndig - 1; d >= 0; d--) begin
      body.push_back(ascii_nibble(wide[4*d +: 4]));
    end
    body.push_back(sfe_pkg::CH_ETX);
    sum = 8'd0;
    chars_due.push_back('{chr: sfe_pkg::CH_SOH, last: 1'b0});
    foreach (body[i]) begin
      sum = sum + body[i];
      chars_due.push_back('{chr: body[i], last: 1'b0});
    end
    chars_due.push_back('{chr: ascii_nibble(sum[7:4]), last: 1'b0});
    chars_due.push_back('{chr: ascii_nibble(sum[3:0]), last: 1'b1});
  endtask

  // Track the station register, check strobed bytes, queue accepted requests
  always @(posedge clk) begin
    frame_char_t want;
    if (rst) begin
      station_now = sfe_pkg::STATION_RESET;
      chars_due.delete();
    end else begin
      if (station_write) begin
        station_now = station;
      end
      if (frame_strobe) begin
        bytes_done++;
        if (chars_due.size() == 0) begin
          $error("frame_byte 0x%02h arrived with no byte expected", frame_byte);
          errors++;
        end else begin
          want = chars_due.pop_front();
          if (frame_byte !== want.chr) begin
            $error("frame_byte: expected 0x%02h, got 0x%02h", want.chr, frame_byte);
            errors++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte: expected %0b, got %0b", want.last, last_byte);
            errors++;
          end
          if (want.last) begin
            frames_done++;
          end
        end
      end
      if (start && !busy) begin
        queue_frame(command_code, data_number, has_data, data_digits, data_value);
      end
    end
    pending = chars_due.size();
  end

endmodule

### sim/tb_servo_serial_frame_encoder_top.sv
`timescale 1ns / 1ps

module tb_servo_serial_frame_encoder_top;

  localparam int unsigned DIGITS_MAX   = 8;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 60;

  logic               clk;
  logic               rst;
  logic               station_write;
  logic [7:0]         station;
  logic               start;
  logic               busy;
  logic [7:0]         command_code;
  logic [7:0]         data_number;
  logic               has_data;
  logic [3:0]         data_digits;
  logic signed [31:0] data_value;
  logic               frame_strobe;
  logic [7:0]         frame_byte;
  logic               last_byte;

  int errors;
  int pending;
  int frames_done;
  int bytes_done;
  int cycle_count;
  int requests_sent;
  int settings_used;
  bit no_idle;

  servo_serial_frame_encoder_top #(
    .MAX_DATA_DIGITS(DIGITS_MAX)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .station_write(station_write),
    .station      (station),
    .start        (start),
    .busy         (busy),
    .command_code (command_code),
    .data_number  (data_number),
    .has_data     (has_data),
    .data_digits  (data_digits),
    .data_value   (data_value),
    .frame_strobe (frame_strobe),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte)
  );

  servo_serial_frame_encoder_checker #(
    .MAX_DATA_DIGITS(DIGITS_MAX)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .station_write(station_write),
    .station      (station),
    .start        (start),
    .busy         (busy),
    .command_code (command_code),
    .data_number  (data_number),
    .has_data     (has_data),
    .data_digits  (data_digits),
    .data_value   (data_value),
    .frame_strobe (frame_strobe),
    .frame_byte   (frame_byte),
    .last_byte    (last_byte),
    .errors       (errors),
    .pending      (pending),
    .frames_done  (frames_done),
    .bytes_done   (bytes_done)
  );

  // Free-running clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frame bytes still due", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Idle length between requests: mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input logic [7:0] cmd, input logic [7:0] dno,
                              input logic has, input logic [3:0] dig,
                              input logic [31:0] val);
    int gap;
    command_code = cmd;
    data_number  = dno;
    has_data     = has;
    data_digits  = dig;
    data_value   = val;
    start        = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random request, biased toward the 4 and 8 digit forms in use
  task automatic send_random_request();
    logic [3:0]  dig;
    logic [31:0] val;
    logic        has;
    int          r;
    has = ($urandom_range(0, 9) < 8);
    r = $urandom_range(0, 9);
    if (r < 4) dig = 4'd4;
    else if (r < 8) dig = 4'd8;
    else dig = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    case (r)
      0:       val = 32'd0;
      1:       val = 32'hFFFF_FFFF;
      2:       val = 32'h8000_0000;
      3:       val = 32'h7FFF_FFFF;
      4:       val = $urandom_range(0, 65535) - 32768;
      default: val = $urandom;
    endcase
    send_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), has, dig, val);
  endtask

  // Drop the request, let the frame in flight drain, then load a new station
  task automatic write_station(input logic [7:0] value);
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
    station_write = 1'b1;
    station       = value;
    @(negedge clk);
    station_write = 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [7:0] next_station;
    rst           = 1'b1;
    station_write = 1'b0;
    station       = 8'h00;
    start         = 1'b0;
    command_code  = 8'h00;
    data_number   = 8'h00;
    has_data      = 1'b0;
    data_digits   = 4'd0;
    data_value    = 32'd0;
    cycle_count   = 0;
    requests_sent = 0;
    settings_used = 1;
    no_idle       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    // Directed requests with the station at its reset value
    send_request(8'h00, 8'h00, 1'b0, 4'd0,  32'h0000_0000);
    send_request(8'hFF, 8'hFF, 1'b0, 4'd15, 32'hFFFF_FFFF);
    send_request(8'h12, 8'h34, 1'b1, 4'd0,  32'h0000_1234);
    send_request(8'h5A, 8'hA5, 1'b1, 4'd4,  32'h0000_7FFF);
    send_request(8'hAB, 8'hCD, 1'b1, 4'd4,  32'hFFFF_FFFF);
    send_request(8'h01, 8'h02, 1'b1, 4'd4,  32'h0001_2345);
    send_request(8'h10, 8'h20, 1'b1, 4'd4,  32'hFFFE_8000);
    send_request(8'h80, 8'h7F, 1'b1, 4'd4,  32'hFFFF_8000);
    send_request(8'hC3, 8'h3C, 1'b1, 4'd8,  32'h8000_0000);
    send_request(8'h3C, 8'hC3, 1'b1, 4'd8,  32'h7FFF_FFFF);
    send_request(8'hFE, 8'hEF, 1'b1, 4'd8,  32'h0000_0000);
    send_request(8'h99, 8'h66, 1'b1, 4'd8,  32'hABCD_EF01);
    send_request(8'h77, 8'h88, 1'b1, 4'd9,  32'h9876_5432);
    send_request(8'hF0, 8'h0F, 1'b1, 4'd15, 32'hDEAD_BEEF);
    send_request(8'h0A, 8'hB0, 1'b1, 4'd1,  32'h0000_000C);
    send_request(8'h2B, 8'hD4, 1'b1, 4'd2,  32'hFFFF_FF9E);
    send_request(8'h4E, 8'h61, 1'b1, 4'd3,  32'h0000_0F1A);
    send_request(8'h6F, 8'h92, 1'b1, 4'd5,  32'hFFF1_2345);
    send_request(8'hE7, 8'h18, 1'b1, 4'd6,  32'h0012_3456);
    send_request(8'hB5, 8'h5B, 1'b1, 4'd7,  32'h0FED_CBA9);

    // Random phases, each under its own station; some without idle cycles
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) next_station = 8'h00;
      else if (p == 1) next_station = 8'hFF;
      else if (p == PHASES - 1) next_station = sfe_pkg::STATION_RESET;
      else next_station = 8'($urandom_range(0, 255));
      write_station(next_station);
      no_idle = (p % 3 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random_request();
      end
    end
    start = 1'b0;

    // Drain the last frame
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("%0d requests over %0d station settings; %0d frames, %0d bytes compared",
             requests_sent, settings_used, frames_done, bytes_done);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### servo_serial_frame_encoder_top.f
rtl/core/sfe_pkg.sv
rtl/core/sfe_useq.sv
rtl/core/servo_serial_frame_encoder_top.sv
sim/servo_serial_frame_encoder_checker.sv
sim/tb_servo_serial_frame_encoder_top.sv
